// ===== hdl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the 2x2 box downscaler
// Pixel and pair-sum types, register indexes and frame size limits.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

    localparam int CH_W     = 8;
    localparam int SUM_W    = CH_W + 1;
    localparam int POS_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

endpackage

`default_nettype wire

// ===== hdl/rbd_line_buf.sv =====
// ----------------------------------------------------------------------------
// rbd_line_buf: line buffer for the upper block row
// One write port and one registered read port holding horizontal pair sums.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_line_buf #(
    parameter int DEPTH  = 28,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire rbd_pkg::t_sums    i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output rbd_pkg::t_sums         o_rd_data
);
    import rbd_pkg::*;

    t_sums r_mem [DEPTH];
    t_sums r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/rgb_box_downscale_2x2.sv =====
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2: 2x2 box-filter downscale of a raster RGB frame
// Averages each 2x2 block per channel and emits the top-left output pixels.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  pixel    in         i_pix_valid / o_pix_ready i_pixel_red/green/blue
//  result   out        o_out_valid / i_out_ready o_out_red/green/blue, col, row
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle while o_pix_ready is high. A result passes
// from the pixel that completes its block through the stage register, fed by
// the line buffer read, and then through the output register.
// Reset is synchronous; the line buffer is not cleared and needs no pass.
// A stalled output register backs up into the stage register and then into
// o_pix_ready; while the stage holds a result that cannot move, every pixel
// waits, including pixels that give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_box_downscale_2x2 #(
    parameter int  OUT_SIZE = 28,
    localparam int COORD_W  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_pix_valid,
    output logic                               o_pix_ready,
    input  wire logic [rbd_pkg::CH_W-1:0]      i_pixel_red,
    input  wire logic [rbd_pkg::CH_W-1:0]      i_pixel_green,
    input  wire logic [rbd_pkg::CH_W-1:0]      i_pixel_blue,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rbd_pkg::CH_W-1:0]           o_out_red,
    output logic [rbd_pkg::CH_W-1:0]           o_out_green,
    output logic [rbd_pkg::CH_W-1:0]           o_out_blue,
    output logic [COORD_W-1:0]                 o_out_col,
    output logic [COORD_W-1:0]                 o_out_row,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rbd_pkg::SIZE_W-1:0]    i_cfg_data
);
    import rbd_pkg::*;

    localparam logic [SIZE_W-1:0] AREA_LIM = SIZE_W'(2 * OUT_SIZE);

    // Configuration and position state.
    logic [SIZE_W-1:0] r_width, r_height;
    logic [POS_W-1:0]  r_col, r_row;
    t_pixel            r_held;

    // Stage register.
    logic               r_s1_valid;
    t_sums              r_s1_sums;
    logic               r_s1_hshift;
    logic               r_s1_odd_row;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;

    // Output register.
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_red, r_out_green, r_out_blue;
    logic [COORD_W-1:0] r_out_col, r_out_row;

    logic [SIZE_W-1:0]  eff_w, eff_h;
    logic [SIZE_W-1:0]  col_next, row_next;
    logic               pix_accept, cfg_accept;
    logic               in_area, even_col, hold_left, pair_done, keep_upper, emit;
    logic [COORD_W-1:0] blk_x, blk_y;
    t_pixel             pix;
    t_sums              pair_sums, upper;
    logic               out_free, s1_move;
    logic [SUM_W:0]     tot_red, tot_green, tot_blue;
    logic [1:0]         shift;

    always_comb begin
        if (r_width == '0) begin
            eff_w = SIZE_MIN;
        end else if (r_width > SIZE_MAX) begin
            eff_w = SIZE_MAX;
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = SIZE_MIN;
        end else if (r_height > SIZE_MAX) begin
            eff_h = SIZE_MAX;
        end else begin
            eff_h = r_height;
        end
    end

    assign pix        = '{red: i_pixel_red, green: i_pixel_green, blue: i_pixel_blue};
    assign col_next   = {1'b0, r_col} + SIZE_W'(1);
    assign row_next   = {1'b0, r_row} + SIZE_W'(1);
    assign in_area    = ({1'b0, r_col} < AREA_LIM) && ({1'b0, r_row} < AREA_LIM);
    assign even_col   = ~r_col[0];
    assign hold_left  = even_col && (col_next < eff_w);
    assign pair_done  = in_area && !hold_left;
    assign keep_upper = ~r_row[0] && (row_next < eff_h);
    assign emit       = pair_done && !keep_upper;
    assign blk_x      = r_col[COORD_W:1];
    assign blk_y      = r_row[COORD_W:1];

    // Horizontal pair sum: the lone pixel at an odd right edge, else the pair.
    always_comb begin
        if (even_col) begin
            pair_sums = '{red:   {1'b0, pix.red},
                          green: {1'b0, pix.green},
                          blue:  {1'b0, pix.blue}};
        end else begin
            pair_sums = '{red:   {1'b0, pix.red}   + {1'b0, r_held.red},
                          green: {1'b0, pix.green} + {1'b0, r_held.green},
                          blue:  {1'b0, pix.blue}  + {1'b0, r_held.blue}};
        end
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_move     = r_s1_valid && out_free;
    assign o_pix_ready = !r_s1_valid || out_free;
    assign pix_accept  = i_pix_valid && o_pix_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;

    rbd_line_buf #(
        .DEPTH  (OUT_SIZE),
        .ADDR_W (COORD_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (pix_accept && pair_done && keep_upper),
        .i_wr_addr (blk_x),
        .i_wr_data (pair_sums),
        .i_rd_en   (pix_accept),
        .i_rd_addr (blk_x),
        .o_rd_data (upper)
    );

    // Size registers and raster position; a size write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(2 * 28);
            r_height <= SIZE_W'(2 * 28);
            r_col    <= '0;
            r_row    <= '0;
            r_held   <= '0;
        end else if (cfg_accept) begin
            if (i_cfg_index == CFG_IN_WIDTH) begin
                r_width <= i_cfg_data;
                r_col   <= '0;
                r_row   <= '0;
                r_held  <= '0;
            end else if (i_cfg_index == CFG_IN_HEIGHT) begin
                r_height <= i_cfg_data;
                r_col    <= '0;
                r_row    <= '0;
                r_held   <= '0;
            end
        end else if (pix_accept) begin
            if (in_area && hold_left) begin
                r_held <= pix;
            end
            if (col_next >= eff_w) begin
                r_col <= '0;
                if (row_next >= eff_h) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_next[POS_W-1:0];
                end
            end else begin
                r_col <= col_next[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_accept) begin
            r_s1_valid <= emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept && emit) begin
            r_s1_sums    <= pair_sums;
            r_s1_hshift  <= ~even_col;
            r_s1_odd_row <= r_row[0];
            r_s1_col     <= blk_x;
            r_s1_row     <= blk_y;
        end
    end

    // Add the upper row's pair sums on an odd row, then divide by the count.
    always_comb begin
        if (r_s1_odd_row) begin
            tot_red   = {1'b0, r_s1_sums.red}   + {1'b0, upper.red};
            tot_green = {1'b0, r_s1_sums.green} + {1'b0, upper.green};
            tot_blue  = {1'b0, r_s1_sums.blue}  + {1'b0, upper.blue};
        end else begin
            tot_red   = {1'b0, r_s1_sums.red};
            tot_green = {1'b0, r_s1_sums.green};
            tot_blue  = {1'b0, r_s1_sums.blue};
        end
        shift = {1'b0, r_s1_hshift} + {1'b0, r_s1_odd_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_red   <= tot_red[CH_W-1+shift -: CH_W];
            r_out_green <= tot_green[CH_W-1+shift -: CH_W];
            r_out_blue  <= tot_blue[CH_W-1+shift -: CH_W];
            r_out_col   <= r_s1_col;
            r_out_row   <= r_s1_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;

endmodule

`default_nettype wire

// ===== bench/rgb_box_downscale_2x2_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2_checker: scoreboard for the 2x2 box downscaler
// Watches the pixel, result and register channels, predicts each averaged
// output pixel from the accepted pixels and compares the results in order.
// ----------------------------------------------------------------------------
module rgb_box_downscale_2x2_checker #(
    parameter int OUT_SIZE = 28,
    parameter int COORD_W  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_pix_valid,
    input  logic                          i_pix_ready,
    input  logic [rbd_pkg::CH_W-1:0]      i_pixel_red,
    input  logic [rbd_pkg::CH_W-1:0]      i_pixel_green,
    input  logic [rbd_pkg::CH_W-1:0]      i_pixel_blue,

    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rbd_pkg::CH_W-1:0]      i_out_red,
    input  logic [rbd_pkg::CH_W-1:0]      i_out_green,
    input  logic [rbd_pkg::CH_W-1:0]      i_out_blue,
    input  logic [COORD_W-1:0]            i_out_col,
    input  logic [COORD_W-1:0]            i_out_row,

    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbd_pkg::SIZE_W-1:0]    i_cfg_data,

    output int                            o_fail_count,
    output int                            o_expected_left,
    output int                            o_results_seen
);

    localparam logic [rbd_pkg::SIZE_W-1:0] RESET_EXTENT = 13'd56;
    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        rbd_pkg::t_pixel    pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_box_avg;

    logic [rbd_pkg::SIZE_W-1:0] width_reg;
    logic [rbd_pkg::SIZE_W-1:0] height_reg;
    logic [rbd_pkg::POS_W-1:0]  col_pos;
    logic [rbd_pkg::POS_W-1:0]  row_pos;
    rbd_pkg::t_pixel            held_left;
    rbd_pkg::t_sums             upper_pair_sums [OUT_SIZE];

    t_box_avg downscaled_q [$];
    int       fail_count   = 0;
    int       results_seen = 0;

    initial begin
        o_fail_count    = 0;
        o_expected_left = 0;
        o_results_seen  = 0;
        for (int i = 0; i < OUT_SIZE; i++) upper_pair_sums[i] = '0;
    end

    function automatic int unsigned frame_extent(input logic [rbd_pkg::SIZE_W-1:0] v);
        if (v < rbd_pkg::SIZE_MIN) return rbd_pkg::SIZE_MIN;
        if (v > rbd_pkg::SIZE_MAX) return rbd_pkg::SIZE_MAX;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic apply_register_write(input logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [rbd_pkg::SIZE_W-1:0] value);
        // A size write restarts the frame; other indexes change nothing.
        if (idx == rbd_pkg::CFG_IN_WIDTH || idx == rbd_pkg::CFG_IN_HEIGHT) begin
            if (idx == rbd_pkg::CFG_IN_WIDTH) width_reg = value;
            else height_reg = value;
            col_pos   = '0;
            row_pos   = '0;
            held_left = '0;
        end
    endtask

    task automatic absorb_pixel(input rbd_pkg::t_pixel px);
        int unsigned    w, h, c, r, x, shift;
        int unsigned    sr, sg, sb;
        bit             emit;
        rbd_pkg::t_sums upper;
        t_box_avg       avg;
        w = frame_extent(width_reg);
        h = frame_extent(height_reg);
        c = col_pos;
        r = row_pos;
        if (c < 2 * OUT_SIZE && r < 2 * OUT_SIZE) begin
            x     = c / 2;
            sr    = px.red;
            sg    = px.green;
            sb    = px.blue;
            shift = 0;
            emit  = 1'b1;
            if (c % 2 == 0) begin
                // An even column waits for its right neighbor unless it is the last one.
                if (c + 1 < w) begin
                    held_left = px;
                    emit      = 1'b0;
                end
            end else begin
                sr    += held_left.red;
                sg    += held_left.green;
                sb    += held_left.blue;
                shift  = 1;
            end
            if (emit) begin
                if (r % 2 == 0) begin
                    if (r + 1 < h) begin
                        upper_pair_sums[x] = {sr[8:0], sg[8:0], sb[8:0]};
                        emit = 1'b0;
                    end
                end else begin
                    upper  = upper_pair_sums[x];
                    sr    += upper.red;
                    sg    += upper.green;
                    sb    += upper.blue;
                    shift += 1;
                end
            end
            if (emit) begin
                sr = sr >> shift;
                sg = sg >> shift;
                sb = sb >> shift;
                avg.pix.red   = sr[7:0];
                avg.pix.green = sg[7:0];
                avg.pix.blue  = sb[7:0];
                avg.col       = x[COORD_W-1:0];
                avg.row       = COORD_W'(r / 2);
                downscaled_q.push_back(avg);
            end
        end
        if (c + 1 >= w) begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : rbd_pkg::POS_W'(r + 1);
        end else begin
            col_pos = rbd_pkg::POS_W'(c + 1);
        end
    endtask

    task automatic check_result();
        t_box_avg want;
        results_seen++;
        if (downscaled_q.size() == 0) begin
            report_mismatch("result with none pending, col", i_out_col, -1);
        end else begin
            want = downscaled_q.pop_front();
            if (i_out_red !== want.pix.red)     report_mismatch("red", i_out_red, want.pix.red);
            if (i_out_green !== want.pix.green)
                report_mismatch("green", i_out_green, want.pix.green);
            if (i_out_blue !== want.pix.blue)   report_mismatch("blue", i_out_blue, want.pix.blue);
            if (i_out_col !== want.col)         report_mismatch("col", i_out_col, want.col);
            if (i_out_row !== want.row)         report_mismatch("row", i_out_row, want.row);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RESET_EXTENT;
            height_reg = RESET_EXTENT;
            col_pos    = '0;
            row_pos    = '0;
            held_left  = '0;
            downscaled_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_register_write(i_cfg_index, i_cfg_data);
            if (i_pix_valid && i_pix_ready)
                absorb_pixel({i_pixel_red, i_pixel_green, i_pixel_blue});
            if (i_out_valid && i_out_ready) check_result();
        end
        o_fail_count    <= fail_count;
        o_expected_left <= downscaled_q.size();
        o_results_seen  <= results_seen;
    end

endmodule

// ===== bench/rgb_box_downscale_2x2_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2_tb: top level of the downscaler testbench
// Drives pixel frames of many sizes and register writes with random gaps
// and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module rgb_box_downscale_2x2_tb;

    localparam int OUT_SIZE       = 28;
    localparam int COORD_W        = $clog2(OUT_SIZE);
    localparam int RANDOM_ITEMS   = 1800;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PHASE      = 240;

    // Indexes that map to no register; a write there must change nothing.
    localparam logic [rbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                          pix_valid = 1'b0;
    logic                          o_pix_ready;
    logic [rbd_pkg::CH_W-1:0]      pix_red   = '0;
    logic [rbd_pkg::CH_W-1:0]      pix_green = '0;
    logic [rbd_pkg::CH_W-1:0]      pix_blue  = '0;

    logic                          o_out_valid;
    logic                          out_ready = 1'b0;
    logic [rbd_pkg::CH_W-1:0]      o_out_red;
    logic [rbd_pkg::CH_W-1:0]      o_out_green;
    logic [rbd_pkg::CH_W-1:0]      o_out_blue;
    logic [COORD_W-1:0]            o_out_col;
    logic [COORD_W-1:0]            o_out_row;

    logic                          cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rbd_pkg::SIZE_W-1:0]    cfg_data  = '0;

    int fail_count;
    int expected_left;
    int results_seen;

    bit          calm          = 1'b0;
    int          out_stall     = 0;
    int          idle_cycles   = 0;
    int          pixels_sent   = 0;
    int          writes_done   = 0;
    int          size_settings = 0;
    int          random_goal;
    int          w_val, h_val, phase_len;
    int unsigned w_ext, h_ext;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rgb_box_downscale_2x2 #(.OUT_SIZE(OUT_SIZE)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel_red   (pix_red),
        .i_pixel_green (pix_green),
        .i_pixel_blue  (pix_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    rgb_box_downscale_2x2_checker #(.OUT_SIZE(OUT_SIZE)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix_valid     (pix_valid),
        .i_pix_ready     (o_pix_ready),
        .i_pixel_red     (pix_red),
        .i_pixel_green   (pix_green),
        .i_pixel_blue    (pix_blue),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_out_red       (o_out_red),
        .i_out_green     (o_out_green),
        .i_out_blue      (o_out_blue),
        .i_out_col       (o_out_col),
        .i_out_row       (o_out_row),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left),
        .o_results_seen  (results_seen)
    );

    // Result side: after a transaction ready now and then drops for a random stretch; never in calm phases.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else if (out_ready) begin
            if (o_out_valid) begin
                out_stall <= calm ? 0 : $urandom_range(0, 11);
                if (!calm) out_ready <= ($urandom_range(0, 11) == 0);
            end
        end else if (out_stall > 1) begin
            out_stall <= out_stall - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((pix_valid && o_pix_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [rbd_pkg::CH_W-1:0] draw_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return rbd_pkg::CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input rbd_pkg::t_pixel px);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_red   <= px.red;
        pix_green <= px.green;
        pix_blue  <= px.blue;
        do @(posedge i_clk); while (!o_pix_ready);
        pixels_sent++;
    endtask

    task automatic push_random_pixel();
        push_pixel({draw_channel(), draw_channel(), draw_channel()});
    endtask

    // The sender holds off until every predicted result has been taken.
    task automatic wait_results_drained();
        pix_valid <= 1'b0;
        do @(posedge i_clk); while (expected_left != 0);
    endtask

    task automatic write_register(input logic [rbd_pkg::CFG_IDX_W-1:0] idx, input int value);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[rbd_pkg::SIZE_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    task automatic set_frame_size(input int width, input int height);
        if ($urandom_range(0, 1)) begin
            write_register(rbd_pkg::CFG_IN_WIDTH, width);
            write_register(rbd_pkg::CFG_IN_HEIGHT, height);
        end else begin
            write_register(rbd_pkg::CFG_IN_HEIGHT, height);
            write_register(rbd_pkg::CFG_IN_WIDTH, width);
        end
        if ($urandom_range(0, 5) == 0)
            write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                           $urandom_range(0, 8191));
        size_settings++;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Partial first row with the sizes left by reset: all pairs go to the line buffer.
        for (int i = 0; i < 4; i++) push_random_pixel();

        // 3x3 frame: full, half and single-pixel blocks at the odd edges.
        set_frame_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            push_pixel({(i % 2) ? 8'd0 : 8'd255, (i % 3 == 0) ? 8'd255 : 8'd0,
                        (i % 2) ? 8'd255 : 8'd1});
            if (i == 4) wait_results_drained();
        end

        // Zero sizes count as one: every pixel is its own block.
        set_frame_size(0, 0);
        push_pixel({8'd255, 8'd255, 8'd255});
        push_pixel({8'd0, 8'd0, 8'd0});

        // Four full-scale pixels give the largest sum.
        set_frame_size(2, 2);
        for (int i = 0; i < 4; i++) push_pixel({8'd255, 8'd255, 8'd255});

        set_frame_size(1, 2);
        push_pixel({8'd255, 8'd0, 8'd128});
        push_pixel({8'd1, 8'd255, 8'd127});

        random_goal = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < random_goal) begin
            case ($urandom_range(0, 19))
                0: begin w_val = 8191;                   h_val = $urandom_range(0, 2);    end
                1: begin w_val = $urandom_range(4096, 4097); h_val = 0;                   end
                2: begin w_val = $urandom_range(1, 4);   h_val = $urandom_range(56, 62);  end
                3: begin w_val = $urandom_range(55, 64); h_val = $urandom_range(1, 5);    end
                4: begin w_val = $urandom_range(0, 8191); h_val = $urandom_range(0, 3);   end
                5: begin w_val = $urandom_range(0, 3);   h_val = $urandom_range(0, 8191); end
                default: begin
                    w_val = $urandom_range(1, 12);
                    h_val = $urandom_range(1, 12);
                end
            endcase
            w_ext = (w_val < rbd_pkg::SIZE_MIN) ? rbd_pkg::SIZE_MIN :
                    (w_val > rbd_pkg::SIZE_MAX) ? rbd_pkg::SIZE_MAX : w_val;
            h_ext = (h_val < rbd_pkg::SIZE_MIN) ? rbd_pkg::SIZE_MIN :
                    (h_val > rbd_pkg::SIZE_MAX) ? rbd_pkg::SIZE_MAX : h_val;
            if (w_ext * h_ext > MAX_PHASE)
                phase_len = $urandom_range(60, MAX_PHASE);
            else
                phase_len = w_ext * h_ext * $urandom_range(1, 2) + $urandom_range(0, 3);
            set_frame_size(w_val, h_val);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 63) == 0) wait_results_drained();
                push_random_pixel();
            end
            calm = 1'b0;
        end

        pix_valid <= 1'b0;
        do @(posedge i_clk); while (expected_left != 0);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        $display("covered %0d pixels over %0d frame sizes with %0d register writes,",
                 pixels_sent, size_settings, writes_done);
        $display("including odd edges, zero and oversized sizes; %0d results compared",
                 results_seen);
        if (fail_count == 0 && expected_left == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
